// ===== design/mbe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared constants, widths and controller/datapath types for the
// escape-time point unit.
// ----------------------------------------------------------------------------
package mbe_pkg;

	localparam int FRAC_BITS = 28;
	localparam int C_W       = 32;
	localparam int CNT_W     = 16;
	// z held between iterations: |z| <= 2
	localparam int Z_W       = FRAC_BITS + 3;
	// floored squares and doubled cross product: |.| <= 2^(F+3)
	localparam int P_W       = FRAC_BITS + 5;
	// freshly updated z, c added in
	localparam int UPD_W     = ((FRAC_BITS + 3 > 31) ? FRAC_BITS + 3 : 31) + 3;

	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;

	localparam logic [CNT_W-1:0] MAX_ITER_RESET = CNT_W'(800);
	localparam logic              ADDR_MAX_ITER  = 1'b0;

	localparam logic [P_W:0]             SQ_FOUR = (P_W + 1)'(4) << FRAC_BITS;
	localparam logic signed [UPD_W-1:0] Z_TWO   = UPD_W'(2) << FRAC_BITS;
	localparam logic signed [UPD_W-1:0] Z_NTWO  = -Z_TWO;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_UPD,
		ST_DONE
	} mbe_state_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic upd;
		logic out_load;
	} mbe_cmd_t;

	typedef struct packed {
		logic first;
		logic sq_gt4;
		logic mag_esc;
		logic lim_hit;
	} mbe_status_t;

endpackage

// ===== design/mbe_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_ctrl
// Sequencer: accepts a point, alternates multiply and update steps until
// escape or limit, then hands the result to the output register.
// ----------------------------------------------------------------------------
module mbe_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  mbe_pkg::mbe_status_t st,
	output mbe_pkg::mbe_cmd_t    cmd
);

	mbe_pkg::mbe_state_t state_q, state_nx;
	logic                out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mbe_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			mbe_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = mbe_pkg::ST_MUL;
				end
			end
			mbe_pkg::ST_MUL: begin
				cmd.mul  = 1'b1;
				state_nx = mbe_pkg::ST_UPD;
			end
			mbe_pkg::ST_UPD: begin
				if (!st.first && st.sq_gt4) begin
					state_nx = mbe_pkg::ST_DONE;
				end else begin
					cmd.upd = 1'b1;
					if (st.lim_hit || st.mag_esc) begin
						state_nx = mbe_pkg::ST_DONE;
					end else begin
						state_nx = mbe_pkg::ST_MUL;
					end
				end
			end
			mbe_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_nx     = mbe_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = mbe_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== design/mbe_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_datapath
// z registers, three parallel fixed-point multipliers, the z update with
// escape tests, the iteration counter and the result register.
// ----------------------------------------------------------------------------
module mbe_datapath (
	input  logic                            clk,
	input  logic signed [mbe_pkg::C_W-1:0]  c_re,
	input  logic signed [mbe_pkg::C_W-1:0]  c_im,
	input  logic [mbe_pkg::CNT_W-1:0]       max_iter,
	input  mbe_pkg::mbe_cmd_t               cmd,
	output mbe_pkg::mbe_status_t            st,
	output logic [mbe_pkg::CNT_W-1:0]       iter_count,
	output logic                            inside_res
);

	logic signed [mbe_pkg::C_W-1:0]     c_re_q, c_im_q;
	logic signed [mbe_pkg::Z_W-1:0]     z_re_q, z_im_q;
	logic signed [mbe_pkg::P_W-1:0]     sre_q, sim_q, xy_q;
	logic [mbe_pkg::CNT_W-1:0]          n_q;
	logic [mbe_pkg::CNT_W-1:0]          n_inc;
	logic [mbe_pkg::CNT_W-1:0]          iter_count_q;
	logic                               inside_q;

	logic signed [2*mbe_pkg::Z_W-1:0]   prod_rr, prod_ii, prod_ri;
	logic signed [2*mbe_pkg::Z_W-1:0]   sh_rr, sh_ii, sh_ri;
	logic signed [mbe_pkg::UPD_W-1:0]   new_re, new_im;
	logic [mbe_pkg::P_W:0]              sq_sum;

	assign prod_rr = z_re_q * z_re_q;
	assign prod_ii = z_im_q * z_im_q;
	assign prod_ri = z_re_q * z_im_q;

	// floor toward minus infinity; cross term carries the factor of two
	assign sh_rr = prod_rr >>> mbe_pkg::FRAC_BITS;
	assign sh_ii = prod_ii >>> mbe_pkg::FRAC_BITS;
	assign sh_ri = prod_ri >>> (mbe_pkg::FRAC_BITS - 1);

	assign new_re = mbe_pkg::UPD_W'(sre_q) - mbe_pkg::UPD_W'(sim_q)
		+ mbe_pkg::UPD_W'(c_re_q);
	assign new_im = mbe_pkg::UPD_W'(xy_q) + mbe_pkg::UPD_W'(c_im_q);

	assign sq_sum = {1'b0, sre_q[mbe_pkg::P_W-1:0]} + {1'b0, sim_q[mbe_pkg::P_W-1:0]};
	assign n_inc  = n_q + mbe_pkg::CNT_W'(1);

	assign st.first   = (n_q == '0);
	assign st.sq_gt4  = (sq_sum > mbe_pkg::SQ_FOUR);
	assign st.mag_esc = (new_re > mbe_pkg::Z_TWO) || (new_re < mbe_pkg::Z_NTWO)
		|| (new_im > mbe_pkg::Z_TWO) || (new_im < mbe_pkg::Z_NTWO);
	assign st.lim_hit = (n_inc >= max_iter);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			c_re_q <= c_re;
			c_im_q <= c_im;
			z_re_q <= '0;
			z_im_q <= '0;
			n_q    <= '0;
		end else if (cmd.upd) begin
			z_re_q <= new_re[mbe_pkg::Z_W-1:0];
			z_im_q <= new_im[mbe_pkg::Z_W-1:0];
			n_q    <= n_inc;
		end
		if (cmd.mul) begin
			sre_q <= sh_rr[mbe_pkg::P_W-1:0];
			sim_q <= sh_ii[mbe_pkg::P_W-1:0];
			xy_q  <= sh_ri[mbe_pkg::P_W-1:0];
		end
		if (cmd.out_load) begin
			iter_count_q <= n_q;
			inside_q     <= (n_q == max_iter);
		end
	end

	assign iter_count = iter_count_q;
	assign inside_res = inside_q;

endmodule

// ===== design/mandelbrot_escape_time.sv =====
`timescale 1ns / 1ps
// From accept to result, each iteration is one multiply step and one update step,
// then the done state loads the output register unless an output stall holds it.
// Throughput: one item at a time; the next item is taken the cycle after the
// result enters the output register.
// Reset: asynchronous, active low; max_iter returns to 800, no item in flight.
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Escape-time iteration of z = z*z + c for one Q4.28 point, with an APB
// register for the iteration limit.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [mbe_pkg::C_W-1:0]    c_re,
	input  logic signed [mbe_pkg::C_W-1:0]    c_im,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [mbe_pkg::CNT_W-1:0]         iter_count,
	output logic                              inside_res,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [mbe_pkg::PADDR_W-1:0]       paddr,
	input  logic [mbe_pkg::PDATA_W-1:0]       pwdata,
	output logic [mbe_pkg::PDATA_W-1:0]       prdata,
	output logic                              pready
);

	logic [mbe_pkg::CNT_W-1:0] max_iter_q;
	logic                      reg_sel;
	mbe_pkg::mbe_cmd_t         cmd;
	mbe_pkg::mbe_status_t      st;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == mbe_pkg::ADDR_MAX_ITER);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q <= mbe_pkg::MAX_ITER_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			max_iter_q <= pwdata[mbe_pkg::CNT_W-1:0];
		end
	end

	assign prdata = reg_sel ? mbe_pkg::PDATA_W'(max_iter_q) : '0;

	mbe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.st        (st),
		.cmd       (cmd)
	);

	mbe_datapath u_dp (
		.clk        (clk),
		.c_re       (c_re),
		.c_im       (c_im),
		.max_iter   (max_iter_q),
		.cmd        (cmd),
		.st         (st),
		.iter_count (iter_count),
		.inside_res (inside_res)
	);

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (iter_count != '0))
		else $error("result count is zero");

	a_inside_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (inside_res == (iter_count == max_iter_q)))
		else $error("inside flag disagrees with count and limit");

	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((iter_count <= max_iter_q) || (max_iter_q == '0)))
		else $error("count exceeds iteration limit");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("new item taken while point in progress");

endmodule

// ===== verif/mandelbrot_escape_time_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_test
// Drives Q4.28 sample points into the escape-time unit under several
// iteration limits and idle/stall mixes. Each accepted point is run through
// a cycle-free fixed-point predictor, and every result is checked in order.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_test;

	localparam logic [mbe_pkg::PADDR_W-1:0] REG_MAX_ITER = mbe_pkg::PADDR_W'(0);
	localparam logic [mbe_pkg::PADDR_W-1:0] REG_SPARE    = mbe_pkg::PADDR_W'(4);
	localparam int                 CYCLE_LIMIT  = 4000000;
	localparam int                 PRINT_LIMIT  = 40;
	localparam logic [63:0]        Q_TWO        = 64'd2 << mbe_pkg::FRAC_BITS;
	localparam logic [63:0]        Q_FOUR       = 64'd4 << mbe_pkg::FRAC_BITS;

	typedef struct packed {
		logic [mbe_pkg::CNT_W-1:0] count;
		logic                      in_set;
	} escape_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             in_valid = 1'b0;
	logic                             in_stall;
	logic signed [mbe_pkg::C_W-1:0]   c_re = '0;
	logic signed [mbe_pkg::C_W-1:0]   c_im = '0;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	logic [mbe_pkg::CNT_W-1:0]        iter_count;
	logic                             inside_res;
	logic                             psel = 1'b0;
	logic                             penable = 1'b0;
	logic                             pwrite = 1'b0;
	logic [mbe_pkg::PADDR_W-1:0]      paddr = '0;
	logic [mbe_pkg::PDATA_W-1:0]      pwdata = '0;
	logic [mbe_pkg::PDATA_W-1:0]      prdata;
	logic                             pready;

	logic [mbe_pkg::CNT_W-1:0] iter_limit = mbe_pkg::MAX_ITER_RESET;
	escape_t          pending_escapes[$];
	escape_t          head;
	int               mismatch_count = 0;
	int               cycle_count = 0;
	int               send_idle_pct = 0;
	int               stall_pct = 0;
	int               hold_left = 0;

	mandelbrot_escape_time dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.c_re       (c_re),
		.c_im       (c_im),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.iter_count (iter_count),
		.inside_res (inside_res),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[mandelbrot_escape_time] ERROR");
			$finish;
		end
	end

	function automatic logic [63:0] mag_q(input logic signed [63:0] x);
		return x[63] ? 64'(-x) : 64'(x);
	endfunction

	// floor(x*x / 2^F) of the exact product
	function automatic logic signed [63:0] square_q(input logic signed [63:0] x);
		logic [127:0] m;
		logic [127:0] p;
		m = {64'd0, mag_q(x)};
		p = m * m;
		return p[mbe_pkg::FRAC_BITS +: 64];
	endfunction

	// floor(x*y / 2^(F-1)): twice the product, rounded toward minus infinity
	function automatic logic signed [63:0] cross2_q(input logic signed [63:0] x,
			input logic signed [63:0] y);
		logic signed [127:0] a;
		logic signed [127:0] b;
		logic signed [127:0] p;
		a = x;
		b = y;
		p = a * b;
		p = p >>> (mbe_pkg::FRAC_BITS - 1);
		return p[63:0];
	endfunction

	function automatic escape_t predict_escape(input logic signed [mbe_pkg::C_W-1:0] cr,
			input logic signed [mbe_pkg::C_W-1:0] ci,
			input logic [mbe_pkg::CNT_W-1:0] limit);
		logic signed [63:0] cr64;
		logic signed [63:0] ci64;
		logic signed [63:0] zr;
		logic signed [63:0] zi;
		logic signed [63:0] sr;
		logic signed [63:0] si;
		logic signed [63:0] tp;
		logic [31:0]        n;
		logic               gone;
		escape_t            r;
		cr64 = cr;
		ci64 = ci;
		zr = '0;
		zi = '0;
		n = '0;
		do begin
			sr = square_q(zr);
			si = square_q(zi);
			tp = cross2_q(zr, zi);
			zr = sr - si + cr64;
			zi = tp + ci64;
			n = n + 1;
			if (mag_q(zr) > Q_TWO || mag_q(zi) > Q_TWO)
				gone = 1'b1;
			else
				gone = (64'(square_q(zr)) + 64'(square_q(zi))) > Q_FOUR;
		end while (n < {16'd0, limit} && !gone);
		r.count = n[mbe_pkg::CNT_W-1:0];
		r.in_set = (n == {16'd0, limit});
		return r;
	endfunction

	function automatic logic signed [mbe_pkg::C_W-1:0] q28(input real v);
		return $rtoi(v * (2.0 ** mbe_pkg::FRAC_BITS));
	endfunction

	function automatic logic signed [mbe_pkg::C_W-1:0] q28_between(input real lo,
			input real hi);
		return q28(lo + (hi - lo) * ($urandom / 4294967296.0));
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatch_count < PRINT_LIMIT)
			$display("mismatch at %0t ns: %s", $time, what);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_escapes.size() == 0) begin
				report_mismatch($sformatf("unexpected item count=%0d inside=%0b",
					iter_count, inside_res));
			end else begin
				head = pending_escapes.pop_front();
				if (iter_count !== head.count)
					report_mismatch($sformatf("iter_count %0d, predicted %0d",
						iter_count, head.count));
				if (inside_res !== head.in_set)
					report_mismatch($sformatf("inside_res %0b, predicted %0b",
						inside_res, head.in_set));
			end
		end
	end

	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic send_point(input logic signed [mbe_pkg::C_W-1:0] re,
			input logic signed [mbe_pkg::C_W-1:0] im);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		c_re <= re;
		c_im <= im;
		do @(posedge clk); while (in_stall);
		pending_escapes.push_back(predict_escape(re, im, iter_limit));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_escapes.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic apb_access(input logic [mbe_pkg::PADDR_W-1:0] addr, input logic wr,
			input logic [mbe_pkg::PDATA_W-1:0] data,
			output logic [mbe_pkg::PDATA_W-1:0] rd);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic check_limit_reg();
		logic [mbe_pkg::PDATA_W-1:0] rd;
		apb_access(REG_MAX_ITER, 1'b0, '0, rd);
		if (rd !== mbe_pkg::PDATA_W'(iter_limit))
			report_mismatch($sformatf("max_iter reads %0d, holds %0d", rd, iter_limit));
	endtask

	task automatic set_limit(input logic [mbe_pkg::CNT_W-1:0] value);
		logic [mbe_pkg::PDATA_W-1:0] rd;
		apb_access(REG_MAX_ITER, 1'b1, mbe_pkg::PDATA_W'(value), rd);
		iter_limit = value;
		check_limit_reg();
	endtask

	task automatic send_random_point();
		int k;
		k = $urandom_range(99);
		if (k < 55)
			send_point(q28_between(-2.0, 0.5), q28_between(-1.25, 1.25));
		else if (k < 70)
			send_point(q28_between(-0.8, -0.7), q28_between(-0.2, 0.2));
		else if (k < 80)
			send_point(q28_between(0.24, 0.3), q28_between(-0.05, 0.05));
		else if (k < 95)
			send_point($urandom, $urandom);
		else
			case ($urandom_range(3))
				0: send_point(32'sh7FFF_FFFF, $urandom);
				1: send_point(32'sh8000_0000, $urandom);
				2: send_point($urandom, 32'sh7FFF_FFFF);
				default: send_point(q28(-2.0), $urandom_range(1) ? q28(2.0) : 32'sd0);
			endcase
	endtask

	task automatic test_reset_limit();
		check_limit_reg();
	endtask

	task automatic test_directed_points();
		send_point(32'sd0, 32'sd0);
		send_point(q28(-2.0), 32'sd0);
		send_point(q28(2.0), 32'sd0);
		send_point(32'sd0, q28(2.0));
		send_point(32'sd0, q28(-2.0));
		send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		send_point(32'sh8000_0000, 32'sh8000_0000);
		send_point(32'sh7FFF_FFFF, 32'sh8000_0000);
		send_point(32'sh8000_0000, 32'sh7FFF_FFFF);
		send_point(q28(0.25), 32'sd0);
		send_point(q28(-0.75), q28(0.1));
		send_point(q28(-1.0), 32'sd0);
		send_point(32'sd1, -32'sd1);
		drain_results();
	endtask

	task automatic test_limit_extremes();
		// zero limit still runs one iteration
		set_limit(16'd0);
		send_point(32'sd0, 32'sd0);
		send_point(32'sh7FFF_FFFF, 32'sd0);
		drain_results();
		// escape on the step that hits the limit still counts as inside
		set_limit(16'd1);
		send_point(32'sd0, 32'sd0);
		send_point(32'sh8000_0000, 32'sh7FFF_FFFF);
		drain_results();
		set_limit(16'd2);
		send_point(q28(2.0), 32'sd0);
		drain_results();
		set_limit(16'hFFFF);
		send_point(32'sd0, 32'sd0);
		send_point(q28(0.26), 32'sd0);
		drain_results();
	endtask

	task automatic test_unmapped_write();
		logic [mbe_pkg::PDATA_W-1:0] rd;
		set_limit(16'd40);
		apb_access(REG_SPARE, 1'b1, 32'd5, rd);
		check_limit_reg();
		send_point(32'sd0, 32'sd0);
		drain_results();
	endtask

	task automatic test_backpressure();
		set_limit(16'd32);
		send_idle_pct = 0;
		stall_pct = 0;
		hold_left = 400;
		repeat (10) send_random_point();
		drain_results();
		repeat (10) send_random_point();
		drain_results();
	endtask

	task automatic test_random_traffic(input int items,
			input logic [mbe_pkg::CNT_W-1:0] limit,
			input int idle_pct, input int stall_rate);
		set_limit(limit);
		send_idle_pct = idle_pct;
		stall_pct = stall_rate;
		for (int i = 0; i < items; i++) begin
			send_random_point();
			if ($urandom_range(24) == 0) begin
				in_valid <= 1'b0;
				while (pending_escapes.size() != 0)
					@(posedge clk);
			end
		end
		drain_results();
		send_idle_pct = 0;
		stall_pct = 0;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_limit();
		test_directed_points();
		test_limit_extremes();
		test_unmapped_write();
		test_backpressure();
		test_random_traffic(200, 16'd64, 0, 0);
		test_random_traffic(150, 16'd200, 74, 0);
		test_random_traffic(200, 16'd24, 0, 74);
		test_random_traffic(180, mbe_pkg::CNT_W'($urandom_range(16, 300)), 8, 8);
		test_random_traffic(30, mbe_pkg::MAX_ITER_RESET, 74, 74);
		drain_results();
		if (mismatch_count == 0)
			$display("[mandelbrot_escape_time] OK");
		else
			$display("[mandelbrot_escape_time] ERROR");
		$finish;
	end

endmodule
